/* src/qarc_pkg.sv */
// ----------------------------------------------------------------------------
// qarc_pkg
// Shared types and constants for the quaternion attitude rate command block.
// ----------------------------------------------------------------------------
`default_nettype none

package qarc_pkg;

    localparam int QUAT_FRAC_BITS_DEF = 14;

    localparam int QUAT_W    = 16;
    localparam int RATE_W    = 16;
    localparam int GAIN_W    = 12;
    localparam int GAIN_FRAC = 8;
    localparam int RATE_FRAC = 10;

    // APB register file
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [1:0] REG_GAIN_ROLL  = 2'd0;
    localparam logic [1:0] REG_GAIN_PITCH = 2'd1;
    localparam logic [1:0] REG_GAIN_YAW   = 2'd2;

    localparam logic [GAIN_W-1:0] GAIN_ROLL_RST  = 12'd1664;
    localparam logic [GAIN_W-1:0] GAIN_PITCH_RST = 12'd1664;
    localparam logic [GAIN_W-1:0] GAIN_YAW_RST   = 12'd717;

    typedef struct packed {
        logic signed [QUAT_W-1:0] w;
        logic signed [QUAT_W-1:0] x;
        logic signed [QUAT_W-1:0] y;
        logic signed [QUAT_W-1:0] z;
    } quat_t;

    typedef struct packed {
        logic [GAIN_W-1:0] roll;
        logic [GAIN_W-1:0] pitch;
        logic [GAIN_W-1:0] yaw;
    } gains_t;

endpackage

`default_nettype wire

/* src/qarc_regs.sv */
// ----------------------------------------------------------------------------
// qarc_regs
// APB register file holding the three attitude gains.
// ----------------------------------------------------------------------------
`default_nettype none

module qarc_regs
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [qarc_pkg::APB_ADDR_W-1:0]     paddr,
    input  wire logic [qarc_pkg::APB_DATA_W-1:0]     pwdata,
    output logic      [qarc_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                     pready,
    output qarc_pkg::gains_t                         gains
);

    qarc_pkg::gains_t gains_reg;
    logic [1:0]       idx;
    logic             wr_en;

    assign idx    = paddr[qarc_pkg::APB_ADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign gains  = gains_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gains_reg.roll  <= qarc_pkg::GAIN_ROLL_RST;
            gains_reg.pitch <= qarc_pkg::GAIN_PITCH_RST;
            gains_reg.yaw   <= qarc_pkg::GAIN_YAW_RST;
        end
        else if (wr_en)
        begin
            case (idx)
                qarc_pkg::REG_GAIN_ROLL:  gains_reg.roll  <= pwdata[qarc_pkg::GAIN_W-1:0];
                qarc_pkg::REG_GAIN_PITCH: gains_reg.pitch <= pwdata[qarc_pkg::GAIN_W-1:0];
                qarc_pkg::REG_GAIN_YAW:   gains_reg.yaw   <= pwdata[qarc_pkg::GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            qarc_pkg::REG_GAIN_ROLL:
                prdata = qarc_pkg::APB_DATA_W'(gains_reg.roll);
            qarc_pkg::REG_GAIN_PITCH:
                prdata = qarc_pkg::APB_DATA_W'(gains_reg.pitch);
            qarc_pkg::REG_GAIN_YAW:
                prdata = qarc_pkg::APB_DATA_W'(gains_reg.yaw);
            default:
                prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

/* src/qarc_hamilton.sv */
// ----------------------------------------------------------------------------
// qarc_hamilton
// Two-stage error quaternion: conj(cur) * ref, sixteen truncated products
// in the first stage, four-term sums and error scalar sign in the second.
// ----------------------------------------------------------------------------
`default_nettype none

module qarc_hamilton
#(
    parameter int QUAT_FRAC_BITS = qarc_pkg::QUAT_FRAC_BITS_DEF,
    localparam int PROD_W = 2 * (qarc_pkg::QUAT_W + 1),
    localparam int TERM_W = PROD_W - QUAT_FRAC_BITS,
    localparam int ERR_W  = TERM_W + 2
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire qarc_pkg::quat_t         cur_q,
    input  wire qarc_pkg::quat_t         ref_q,
    output logic                         err_valid,
    input  wire logic                    err_ready,
    output logic signed [ERR_W-1:0]      err_v [3],
    output logic                         err_neg
);

    localparam int QE_W = qarc_pkg::QUAT_W + 1;

    logic signed [QE_W-1:0]   p [4];
    logic signed [QE_W-1:0]   q [4];

    logic signed [TERM_W-1:0] term_next [4][4];
    logic signed [TERM_W-1:0] term_reg  [4][4];
    logic signed [ERR_W-1:0]  t         [4][4];

    logic signed [ERR_W-1:0]  ew_next;
    logic signed [ERR_W-1:0]  ev_next [3];
    logic signed [ERR_W-1:0]  ev_reg  [3];
    logic                     neg_reg;

    logic v1_reg;
    logic v2_reg;
    logic adv1;
    logic adv2;

    assign adv2     = !v2_reg || err_ready;
    assign adv1     = !v1_reg || adv2;
    assign in_ready = adv1;

    // current quaternion is conjugated; widened so that -(-2.0) fits
    assign p[0] = {ref_q.w[qarc_pkg::QUAT_W-1], ref_q.w};
    assign p[1] = {ref_q.x[qarc_pkg::QUAT_W-1], ref_q.x};
    assign p[2] = {ref_q.y[qarc_pkg::QUAT_W-1], ref_q.y};
    assign p[3] = {ref_q.z[qarc_pkg::QUAT_W-1], ref_q.z};
    assign q[0] = {cur_q.w[qarc_pkg::QUAT_W-1], cur_q.w};
    assign q[1] = -{cur_q.x[qarc_pkg::QUAT_W-1], cur_q.x};
    assign q[2] = -{cur_q.y[qarc_pkg::QUAT_W-1], cur_q.y};
    assign q[3] = -{cur_q.z[qarc_pkg::QUAT_W-1], cur_q.z};

    for (genvar i = 0; i < 4; i++)
    begin : g_row
        for (genvar j = 0; j < 4; j++)
        begin : g_col
            logic signed [PROD_W-1:0] prod;
            assign prod            = p[i] * q[j];
            // upper bits = floor shift by the fraction width
            assign term_next[i][j] = prod[PROD_W-1:QUAT_FRAC_BITS];
            assign t[i][j]         = ERR_W'(term_reg[i][j]);
        end
    end

    assign ew_next    = t[0][0] - t[1][1] - t[2][2] - t[3][3];
    assign ev_next[0] = t[0][1] + t[1][0] - t[2][3] + t[3][2];
    assign ev_next[1] = t[0][2] + t[1][3] + t[2][0] - t[3][1];
    assign ev_next[2] = t[0][3] - t[1][2] + t[2][1] + t[3][0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                v1_reg <= in_valid;
            end
            if (adv2)
            begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1 && in_valid)
        begin
            term_reg <= term_next;
        end
        if (adv2 && v1_reg)
        begin
            ev_reg  <= ev_next;
            neg_reg <= ew_next[ERR_W-1];
        end
    end

    assign err_valid = v2_reg;
    assign err_v     = ev_reg;
    assign err_neg   = neg_reg;

endmodule

`default_nettype wire

/* src/qarc_rate.sv */
// ----------------------------------------------------------------------------
// qarc_rate
// Two-stage rate command: signed gain multiply, then rescale and saturate.
// ----------------------------------------------------------------------------
`default_nettype none

module qarc_rate
#(
    parameter int QUAT_FRAC_BITS = qarc_pkg::QUAT_FRAC_BITS_DEF,
    localparam int ERR_W = 2 * (qarc_pkg::QUAT_W + 1) - QUAT_FRAC_BITS + 2
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           err_valid,
    output logic                                err_ready,
    input  wire logic signed [ERR_W-1:0]        err_v [3],
    input  wire logic                           err_neg,
    input  wire qarc_pkg::gains_t               gains,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic signed [qarc_pkg::RATE_W-1:0]  rate [3]
);

    localparam int SE_W   = ERR_W + 1;
    localparam int PROD_W = SE_W + qarc_pkg::GAIN_W + 1;
    // the factor of two folds into the shift
    localparam int SHIFT  = QUAT_FRAC_BITS + qarc_pkg::GAIN_FRAC - qarc_pkg::RATE_FRAC - 1;
    localparam logic signed [PROD_W-1:0] SAT_HI = PROD_W'(2 ** (qarc_pkg::RATE_W - 1) - 1);
    localparam logic signed [PROD_W-1:0] SAT_LO = -SAT_HI - PROD_W'(1);

    logic [qarc_pkg::GAIN_W-1:0]        g [3];
    logic signed [PROD_W-1:0]           prod_next [3];
    logic signed [PROD_W-1:0]           prod_reg  [3];
    logic signed [qarc_pkg::RATE_W-1:0] rate_next [3];
    logic signed [qarc_pkg::RATE_W-1:0] rate_reg  [3];

    logic v3_reg;
    logic v4_reg;
    logic adv3;
    logic adv4;

    assign adv4      = !v4_reg || out_ready;
    assign adv3      = !v3_reg || adv4;
    assign err_ready = adv3;

    assign g[0] = gains.roll;
    assign g[1] = gains.pitch;
    assign g[2] = gains.yaw;

    for (genvar k = 0; k < 3; k++)
    begin : g_axis
        logic signed [SE_W-1:0]   e_ext;
        logic signed [SE_W-1:0]   se;
        logic signed [PROD_W-1:0] sh;

        assign e_ext        = SE_W'(err_v[k]);
        // zero scalar part counts as positive
        assign se           = err_neg ? -e_ext : e_ext;
        assign prod_next[k] = se * $signed({1'b0, g[k]});

        assign sh = prod_reg[k] >>> SHIFT;

        always_comb
        begin
            if (sh > SAT_HI)
            begin
                rate_next[k] = SAT_HI[qarc_pkg::RATE_W-1:0];
            end
            else if (sh < SAT_LO)
            begin
                rate_next[k] = SAT_LO[qarc_pkg::RATE_W-1:0];
            end
            else
            begin
                rate_next[k] = sh[qarc_pkg::RATE_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (adv3)
            begin
                v3_reg <= err_valid;
            end
            if (adv4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv3 && err_valid)
        begin
            prod_reg <= prod_next;
        end
        if (adv4 && v3_reg)
        begin
            rate_reg <= rate_next;
        end
    end

    assign out_valid = v4_reg;
    assign rate      = rate_reg;

    // a stalled output must hold the product stage
    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && v4_reg && !out_ready) |=> v3_reg)
        else $error("product stage dropped during output stall");

    a_load: assert property (@(posedge clk) disable iff (!rst_n)
        (err_valid && err_ready) |=> v3_reg)
        else $error("error transaction not captured");

    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && adv4 && (prod_reg[0] == '0)) |=> (rate_reg[0] == '0))
        else $error("zero product gave non-zero roll rate");

endmodule

`default_nettype wire

/* src/quaternion_attitude_rate_command.sv */
// Structure: 4 register stages, term, error, product and rate registers in
// that order. Throughput: one attitude pair per cycle while out_ready is
// high; stages 1-2 hold the Hamilton product and sums, stages 3-4 the gain
// multiply and saturation.
// Reset (rst_n, async, active low) empties the pipeline and loads the gains
// with 6.5, 6.5 and about 2.8 (Q4.8).
// ----------------------------------------------------------------------------
// quaternion_attitude_rate_command
// Proportional attitude controller: error quaternion to body-rate commands.
// ----------------------------------------------------------------------------
`default_nettype none

module quaternion_attitude_rate_command
#(
    parameter int QUAT_FRAC_BITS = qarc_pkg::QUAT_FRAC_BITS_DEF
)
(
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,

    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic signed [qarc_pkg::QUAT_W-1:0]    cur_w,
    input  wire logic signed [qarc_pkg::QUAT_W-1:0]    cur_x,
    input  wire logic signed [qarc_pkg::QUAT_W-1:0]    cur_y,
    input  wire logic signed [qarc_pkg::QUAT_W-1:0]    cur_z,
    input  wire logic signed [qarc_pkg::QUAT_W-1:0]    ref_w,
    input  wire logic signed [qarc_pkg::QUAT_W-1:0]    ref_x,
    input  wire logic signed [qarc_pkg::QUAT_W-1:0]    ref_y,
    input  wire logic signed [qarc_pkg::QUAT_W-1:0]    ref_z,

    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic signed [qarc_pkg::RATE_W-1:0]         rate_roll,
    output logic signed [qarc_pkg::RATE_W-1:0]         rate_pitch,
    output logic signed [qarc_pkg::RATE_W-1:0]         rate_yaw,

    input  wire logic                                  psel,
    input  wire logic                                  penable,
    input  wire logic                                  pwrite,
    input  wire logic [qarc_pkg::APB_ADDR_W-1:0]       paddr,
    input  wire logic [qarc_pkg::APB_DATA_W-1:0]       pwdata,
    output logic      [qarc_pkg::APB_DATA_W-1:0]       prdata,
    output logic                                       pready
);

    localparam int ERR_W = 2 * (qarc_pkg::QUAT_W + 1) - QUAT_FRAC_BITS + 2;

    qarc_pkg::quat_t             cur_q;
    qarc_pkg::quat_t             ref_q;
    qarc_pkg::gains_t            gains;
    logic                        err_valid;
    logic                        err_ready;
    logic signed [ERR_W-1:0]     err_v [3];
    logic                        err_neg;
    logic signed [qarc_pkg::RATE_W-1:0] rate [3];

    assign cur_q = '{w: cur_w, x: cur_x, y: cur_y, z: cur_z};
    assign ref_q = '{w: ref_w, x: ref_x, y: ref_y, z: ref_z};

    qarc_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .gains   (gains)
    );

    qarc_hamilton #(.QUAT_FRAC_BITS(QUAT_FRAC_BITS)) u_hamilton
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cur_q     (cur_q),
        .ref_q     (ref_q),
        .err_valid (err_valid),
        .err_ready (err_ready),
        .err_v     (err_v),
        .err_neg   (err_neg)
    );

    qarc_rate #(.QUAT_FRAC_BITS(QUAT_FRAC_BITS)) u_rate
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .err_valid (err_valid),
        .err_ready (err_ready),
        .err_v     (err_v),
        .err_neg   (err_neg),
        .gains     (gains),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .rate      (rate)
    );

    assign rate_roll  = rate[0];
    assign rate_pitch = rate[1];
    assign rate_yaw   = rate[2];

endmodule

`default_nettype wire

/* test/quaternion_attitude_rate_command_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// quaternion_attitude_rate_command_tb
// Drives attitude pairs through the rate command block under a range of gain
// settings and idle patterns. Each accepted pair is run through a local model
// of the error quaternion and gain stages. Every rate triple that comes out is
// checked against the oldest pending prediction.
// ----------------------------------------------------------------------------

module quaternion_attitude_rate_command_tb;

    localparam int     Q_FRAC      = qarc_pkg::QUAT_FRAC_BITS_DEF;
    localparam int     RATE_SHIFT  = Q_FRAC + qarc_pkg::GAIN_FRAC - qarc_pkg::RATE_FRAC;
    localparam longint RATE_MAX    = (longint'(1) <<< (qarc_pkg::RATE_W - 1)) - 1;
    localparam longint RATE_MIN    = -(longint'(1) <<< (qarc_pkg::RATE_W - 1));
    localparam int     CYCLE_LIMIT = 300000;
    localparam int     MAX_REPORTS = 10;
    localparam int     STALL_LEN   = 60;
    localparam int     DRAIN_WAIT  = 12;
    localparam int     RAND_PHASES = 8;
    localparam int     PHASE_ITEMS = 64;

    // no register decodes here, writes must be dropped
    localparam logic [1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        qarc_pkg::quat_t cur;
        qarc_pkg::quat_t goal;
    } attitude_t;

    typedef struct packed {
        logic signed [qarc_pkg::RATE_W-1:0] roll;
        logic signed [qarc_pkg::RATE_W-1:0] pitch;
        logic signed [qarc_pkg::RATE_W-1:0] yaw;
    } rate_cmd_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                               in_valid = 1'b0;
    logic                               in_ready;
    logic signed [qarc_pkg::QUAT_W-1:0] cur_w = '0;
    logic signed [qarc_pkg::QUAT_W-1:0] cur_x = '0;
    logic signed [qarc_pkg::QUAT_W-1:0] cur_y = '0;
    logic signed [qarc_pkg::QUAT_W-1:0] cur_z = '0;
    logic signed [qarc_pkg::QUAT_W-1:0] ref_w = '0;
    logic signed [qarc_pkg::QUAT_W-1:0] ref_x = '0;
    logic signed [qarc_pkg::QUAT_W-1:0] ref_y = '0;
    logic signed [qarc_pkg::QUAT_W-1:0] ref_z = '0;

    logic                               out_valid;
    logic                               out_ready = 1'b0;
    logic signed [qarc_pkg::RATE_W-1:0] rate_roll;
    logic signed [qarc_pkg::RATE_W-1:0] rate_pitch;
    logic signed [qarc_pkg::RATE_W-1:0] rate_yaw;

    logic                              psel = 1'b0;
    logic                              penable = 1'b0;
    logic                              pwrite = 1'b0;
    logic [qarc_pkg::APB_ADDR_W-1:0]   paddr = '0;
    logic [qarc_pkg::APB_DATA_W-1:0]   pwdata = '0;
    logic [qarc_pkg::APB_DATA_W-1:0]   prdata;
    logic                              pready;

    attitude_t        attitude_pending[$];
    rate_cmd_t        rate_expected[$];
    attitude_t        on_offer;
    logic             offering;
    qarc_pkg::gains_t gains;
    int               send_idle_pct = 0;
    int               recv_stall_pct = 0;
    logic             stall_req = 1'b0;
    logic             stall_done = 1'b0;
    int               stall_count = 0;
    int               mismatches = 0;
    int               cycle_count = 0;
    rate_cmd_t        want;

    quaternion_attitude_rate_command #(
        .QUAT_FRAC_BITS (Q_FRAC)
    ) DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .cur_w      (cur_w),
        .cur_x      (cur_x),
        .cur_y      (cur_y),
        .cur_z      (cur_z),
        .ref_w      (ref_w),
        .ref_x      (ref_x),
        .ref_y      (ref_y),
        .ref_z      (ref_z),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .rate_roll  (rate_roll),
        .rate_pitch (rate_pitch),
        .rate_yaw   (rate_yaw),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ---- error quaternion and rate model ----

    // product of two Q2.14 terms, floored back to Q2.14
    function automatic longint frac_mul(longint a, longint b);
        return (a * b) >>> Q_FRAC;
    endfunction

    function automatic logic signed [qarc_pkg::RATE_W-1:0] scale_rate(
        logic [qarc_pkg::GAIN_W-1:0] gain, longint dir, longint e);
        longint v;
        v = (2 * longint'(gain) * dir * e) >>> RATE_SHIFT;
        if (v > RATE_MAX)
            v = RATE_MAX;
        else if (v < RATE_MIN)
            v = RATE_MIN;
        return v[qarc_pkg::RATE_W-1:0];
    endfunction

    function automatic rate_cmd_t rate_command(attitude_t a, qarc_pkg::gains_t g);
        longint q0, q1, q2, q3, p0, p1, p2, p3;
        longint ew, ex, ey, ez, dir;
        rate_cmd_t r;
        // conjugate of the current attitude; -(-32768) needs the wide type
        q0 = longint'($signed(a.cur.w));
        q1 = -longint'($signed(a.cur.x));
        q2 = -longint'($signed(a.cur.y));
        q3 = -longint'($signed(a.cur.z));
        p0 = longint'($signed(a.goal.w));
        p1 = longint'($signed(a.goal.x));
        p2 = longint'($signed(a.goal.y));
        p3 = longint'($signed(a.goal.z));
        ew = frac_mul(p0, q0) - frac_mul(p1, q1) - frac_mul(p2, q2) - frac_mul(p3, q3);
        ex = frac_mul(p0, q1) + frac_mul(p1, q0) - frac_mul(p2, q3) + frac_mul(p3, q2);
        ey = frac_mul(p0, q2) + frac_mul(p1, q3) + frac_mul(p2, q0) - frac_mul(p3, q1);
        ez = frac_mul(p0, q3) - frac_mul(p1, q2) + frac_mul(p2, q1) + frac_mul(p3, q0);
        // zero scalar error takes the positive branch
        dir = (ew < 0) ? -1 : 1;
        r.roll  = scale_rate(g.roll, dir, ex);
        r.pitch = scale_rate(g.pitch, dir, ey);
        r.yaw   = scale_rate(g.yaw, dir, ez);
        return r;
    endfunction

    // ---- stimulus helpers ----

    function automatic attitude_t attitude_pair(int cw, int cx, int cy, int cz,
                                                int rw, int rx, int ry, int rz);
        attitude_t a;
        a.cur.w  = cw[qarc_pkg::QUAT_W-1:0];
        a.cur.x  = cx[qarc_pkg::QUAT_W-1:0];
        a.cur.y  = cy[qarc_pkg::QUAT_W-1:0];
        a.cur.z  = cz[qarc_pkg::QUAT_W-1:0];
        a.goal.w = rw[qarc_pkg::QUAT_W-1:0];
        a.goal.x = rx[qarc_pkg::QUAT_W-1:0];
        a.goal.y = ry[qarc_pkg::QUAT_W-1:0];
        a.goal.z = rz[qarc_pkg::QUAT_W-1:0];
        return a;
    endfunction

    function automatic logic signed [qarc_pkg::QUAT_W-1:0] pick_component();
        int v;
        case ($urandom_range(9))
            0, 1, 2, 3: v = int'($urandom);
            4, 5, 6:    v = int'($urandom_range(32768)) - 16384;
            7:          v = int'($urandom_range(128)) - 64;
            default:
            begin
                case ($urandom_range(6))
                    0:       v = -32768;
                    1:       v = -32767;
                    2:       v = -1;
                    3:       v = 0;
                    4:       v = 1;
                    5:       v = 16384;
                    default: v = 32767;
                endcase
            end
        endcase
        return v[qarc_pkg::QUAT_W-1:0];
    endfunction

    function automatic logic signed [qarc_pkg::QUAT_W-1:0] nudge(
        logic signed [qarc_pkg::QUAT_W-1:0] c);
        int v;
        v = int'(c) + int'($urandom_range(512)) - 256;
        return v[qarc_pkg::QUAT_W-1:0];
    endfunction

    function automatic attitude_t random_attitude();
        attitude_t a;
        a.cur.w = pick_component();
        a.cur.x = pick_component();
        a.cur.y = pick_component();
        a.cur.z = pick_component();
        case ($urandom_range(7))
            0: a.goal = a.cur;
            // sign-flipped reference: same rotation, negative scalar error
            1:
            begin
                a.goal.w = -a.cur.w;
                a.goal.x = -a.cur.x;
                a.goal.y = -a.cur.y;
                a.goal.z = -a.cur.z;
            end
            2, 3:
            begin
                a.goal.w = nudge(a.cur.w);
                a.goal.x = nudge(a.cur.x);
                a.goal.y = nudge(a.cur.y);
                a.goal.z = nudge(a.cur.z);
            end
            default:
            begin
                a.goal.w = pick_component();
                a.goal.x = pick_component();
                a.goal.y = pick_component();
                a.goal.z = pick_component();
            end
        endcase
        return a;
    endfunction

    task automatic set_gain(input logic [1:0] idx,
                            input logic [qarc_pkg::GAIN_W-1:0] value);
        logic [qarc_pkg::APB_DATA_W-1:0] word;
        word = $urandom;
        word[qarc_pkg::GAIN_W-1:0] = value;
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= word;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            qarc_pkg::REG_GAIN_ROLL:  gains.roll  = value;
            qarc_pkg::REG_GAIN_PITCH: gains.pitch = value;
            qarc_pkg::REG_GAIN_YAW:   gains.yaw   = value;
            default: ;
        endcase
        @(negedge clk);
    endtask

    task automatic wait_drained();
        while (attitude_pending.size() != 0 || in_valid || rate_expected.size() != 0)
            @(negedge clk);
    endtask

    // ---- sender ----

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            offering = in_valid;
            if (in_valid && in_ready)
            begin
                rate_expected.push_back(rate_command(on_offer, gains));
                offering = 1'b0;
            end
            if (!offering)
            begin
                if (attitude_pending.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    on_offer = attitude_pending.pop_front();
                    cur_w    <= on_offer.cur.w;
                    cur_x    <= on_offer.cur.x;
                    cur_y    <= on_offer.cur.y;
                    cur_z    <= on_offer.cur.z;
                    ref_w    <= on_offer.goal.w;
                    ref_x    <= on_offer.goal.x;
                    ref_y    <= on_offer.goal.y;
                    ref_z    <= on_offer.goal.z;
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off, counted here so the sender keeps going
    always @(posedge clk)
    begin
        if (!stall_req)
        begin
            stall_count <= 0;
            stall_done  <= 1'b0;
        end
        else if (!stall_done)
        begin
            if (stall_count == STALL_LEN - 1)
                stall_done <= 1'b1;
            stall_count <= stall_count + 1;
        end
    end

    // ---- receiver and checker ----

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (rate_expected.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: rate transaction with none pending: %0d %0d %0d",
                                 $time, rate_roll, rate_pitch, rate_yaw);
                end
                else
                begin
                    want = rate_expected.pop_front();
                    if (rate_roll !== want.roll || rate_pitch !== want.pitch ||
                        rate_yaw !== want.yaw)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("%0t: rate mismatch exp %0d %0d %0d got %0d %0d %0d",
                                     $time, want.roll, want.pitch, want.yaw,
                                     rate_roll, rate_pitch, rate_yaw);
                    end
                end
            end
            out_ready <= (stall_req && !stall_done) ? 1'b0
                                                    : ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("quaternion_attitude_rate_command_tb: FAIL");
            $finish;
        end
    end

    // ---- test sequence ----

    initial
    begin
        gains.roll  = qarc_pkg::GAIN_ROLL_RST;
        gains.pitch = qarc_pkg::GAIN_PITCH_RST;
        gains.yaw   = qarc_pkg::GAIN_YAW_RST;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed pairs at reset gains, no idling
        attitude_pending.push_back(attitude_pair(0, 0, 0, 0, 0, 0, 0, 0));
        attitude_pending.push_back(attitude_pair(16384, 0, 0, 0, 16384, 0, 0, 0));
        // zero scalar error, vector on x then on z
        attitude_pending.push_back(attitude_pair(16384, 0, 0, 0, 0, 16384, 0, 0));
        attitude_pending.push_back(attitude_pair(0, 16384, 0, 0, 0, 0, 16384, 0));
        attitude_pending.push_back(attitude_pair(16384, 0, 0, 0, -16384, 8192, -8192, 4096));
        attitude_pending.push_back(attitude_pair(11585, 11585, 0, 0, 11585, 0, 11585, 0));
        attitude_pending.push_back(attitude_pair(-32768, -32768, -32768, -32768,
                                                 -32768, -32768, -32768, -32768));
        attitude_pending.push_back(attitude_pair(32767, 32767, 32767, 32767,
                                                 32767, 32767, 32767, 32767));
        attitude_pending.push_back(attitude_pair(-32768, -32768, -32768, -32768,
                                                 32767, 32767, 32767, 32767));
        attitude_pending.push_back(attitude_pair(32767, 32767, 32767, 32767,
                                                 -32768, -32768, -32768, -32768));
        attitude_pending.push_back(attitude_pair(21845, -21846, 21845, -21846,
                                                 -21846, 21845, -21846, 21845));
        attitude_pending.push_back(attitude_pair(-21846, 21845, -21846, 21845,
                                                 21845, -21846, 21845, -21846));
        attitude_pending.push_back(attitude_pair(0, 0, 0, 16384, 0, 0, 0, -16384));
        // tiny negative products floor to -1
        attitude_pending.push_back(attitude_pair(1, -1, 1, -1, -1, 1, -1, 1));
        attitude_pending.push_back(attitude_pair(16384, -32768, 32767, -32768,
                                                 16384, 32767, -32768, 32767));
        attitude_pending.push_back(attitude_pair(-16384, 1, 2, 3, 16384, -3, -2, -1));
        wait_drained();

        // back-pressure: receiver holds off while the sender keeps offering
        stall_req = 1'b1;
        repeat (40) attitude_pending.push_back(random_attitude());
        while (!stall_done)
            @(negedge clk);
        stall_req = 1'b0;
        // the test sequence waits here until every rate has come back
        wait_drained();

        for (int p = 0; p < RAND_PHASES; p++)
        begin
            case (p)
                0:
                begin
                    set_gain(qarc_pkg::REG_GAIN_ROLL, '0);
                    set_gain(qarc_pkg::REG_GAIN_PITCH, '0);
                    set_gain(qarc_pkg::REG_GAIN_YAW, '0);
                end
                1:
                begin
                    set_gain(qarc_pkg::REG_GAIN_ROLL, '1);
                    set_gain(qarc_pkg::REG_GAIN_PITCH, '1);
                    set_gain(qarc_pkg::REG_GAIN_YAW, '1);
                end
                2:
                begin
                    set_gain(qarc_pkg::REG_GAIN_ROLL, 12'd1);
                    set_gain(qarc_pkg::REG_GAIN_PITCH, '1);
                    set_gain(qarc_pkg::REG_GAIN_YAW, '0);
                end
                3:
                begin
                    set_gain(qarc_pkg::REG_GAIN_ROLL, '1);
                    set_gain(qarc_pkg::REG_GAIN_PITCH, '0);
                    set_gain(qarc_pkg::REG_GAIN_YAW, 12'd1);
                end
                default:
                begin
                    set_gain(qarc_pkg::REG_GAIN_ROLL, qarc_pkg::GAIN_W'($urandom));
                    set_gain(qarc_pkg::REG_GAIN_PITCH, qarc_pkg::GAIN_W'($urandom));
                    set_gain(qarc_pkg::REG_GAIN_YAW, qarc_pkg::GAIN_W'($urandom));
                end
            endcase
            set_gain(REG_UNUSED, qarc_pkg::GAIN_W'($urandom));

            case (p % 4)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 77;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 77;
                end
                default:
                begin
                    send_idle_pct  = 11;
                    recv_stall_pct = 11;
                end
            endcase

            repeat (PHASE_ITEMS) attitude_pending.push_back(random_attitude());
            wait_drained();
        end

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (DRAIN_WAIT) @(negedge clk);

        if (mismatches == 0 && rate_expected.size() == 0)
            $display("quaternion_attitude_rate_command_tb: PASS");
        else
            $display("quaternion_attitude_rate_command_tb: FAIL");
        $finish;
    end

endmodule

/* sim.f */
src/qarc_pkg.sv
src/qarc_regs.sv
src/qarc_hamilton.sv
src/qarc_rate.sv
src/quaternion_attitude_rate_command.sv
test/quaternion_attitude_rate_command_tb.sv
